@@ design/aafc_pkg.sv @@
// Shared types and constants for the box/frustum classifier.
// Used by aafc_cell, aabb_frustum_classify and tb_top; depends on nothing.
package aafc_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int PLANE_COUNT      = 6;

    // Plane register: nx, ny, nz (Q1.F) and offset, 16-bit signed each
    localparam int FIELD_W     = 16;
    localparam int PLANE_W     = 4 * FIELD_W;
    localparam int CFG_INDEX_W = 3;

    localparam int PROD_W = FIELD_W + COORD_WIDTH;
    localparam int OFS_W  = FIELD_W + NORMAL_FRAC_BITS;
    localparam int DIST_W = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2;

    typedef enum logic [1:0] {
        VIS_OUTSIDE = 2'd0,
        VIS_PARTIAL = 2'd1,
        VIS_INSIDE  = 2'd2
    } vis_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] min_x;
        logic signed [COORD_WIDTH-1:0] min_y;
        logic signed [COORD_WIDTH-1:0] min_z;
        logic signed [COORD_WIDTH-1:0] max_x;
        logic signed [COORD_WIDTH-1:0] max_y;
        logic signed [COORD_WIDTH-1:0] max_z;
    } box_t;

    typedef struct packed {
        logic outside;
        logic partial;
    } verdict_t;

    typedef struct packed {
        box_t     box;
        verdict_t verdict;
    } item_t;

endpackage

@@ design/aafc_cell.sv @@
// One plane cell of the classifier chain: holds one plane register,
// tests the passing box against it over two stages. Depends on aafc_pkg.
module aafc_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           plane_write,
    input  logic [aafc_pkg::PLANE_W-1:0]   plane_data,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  aafc_pkg::item_t                up_item,
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output aafc_pkg::item_t                dn_item
);

    localparam int PW = aafc_pkg::PROD_W;
    localparam int DW = aafc_pkg::DIST_W;
    localparam int FW = aafc_pkg::FIELD_W;

    logic [aafc_pkg::PLANE_W-1:0] plane_reg;

    logic signed [FW-1:0] nx, ny, nz, ofs;

    logic            v1_reg, v2_reg;
    aafc_pkg::item_t s1_item_reg, s2_item_reg;
    logic signed [PW-1:0] pn_reg [3];
    logic signed [PW-1:0] pf_reg [3];
    logic signed [PW-1:0] pn_next [3];
    logic signed [PW-1:0] pf_next [3];

    logic signed [aafc_pkg::COORD_WIDTH-1:0] near_x, near_y, near_z;
    logic signed [aafc_pkg::COORD_WIDTH-1:0] far_x, far_y, far_z;

    logic signed [DW-1:0] ofs_term, dist_near, dist_far;
    aafc_pkg::item_t s2_item_next;
    logic adv1, adv2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else if (plane_write)
        begin
            plane_reg <= plane_data;
        end
    end

    assign nx  = $signed(plane_reg[FW-1:0]);
    assign ny  = $signed(plane_reg[2*FW-1:FW]);
    assign nz  = $signed(plane_reg[3*FW-1:2*FW]);
    assign ofs = $signed(plane_reg[4*FW-1:3*FW]);

    // A negative normal component takes the max corner as nearest
    always_comb
    begin
        near_x = nx[FW-1] ? up_item.box.max_x : up_item.box.min_x;
        far_x  = nx[FW-1] ? up_item.box.min_x : up_item.box.max_x;
        near_y = ny[FW-1] ? up_item.box.max_y : up_item.box.min_y;
        far_y  = ny[FW-1] ? up_item.box.min_y : up_item.box.max_y;
        near_z = nz[FW-1] ? up_item.box.max_z : up_item.box.min_z;
        far_z  = nz[FW-1] ? up_item.box.min_z : up_item.box.max_z;
        pn_next[0] = PW'(nx) * PW'(near_x);
        pn_next[1] = PW'(ny) * PW'(near_y);
        pn_next[2] = PW'(nz) * PW'(near_z);
        pf_next[0] = PW'(nx) * PW'(far_x);
        pf_next[1] = PW'(ny) * PW'(far_y);
        pf_next[2] = PW'(nz) * PW'(far_z);
    end

    assign adv2     = !v2_reg || dn_ready;
    assign adv1     = !v1_reg || adv2;
    assign up_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= up_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Stage one: hold the six products and the box
    always_ff @(posedge clk)
    begin
        if (up_valid && adv1)
        begin
            s1_item_reg <= up_item;
            for (int a = 0; a < 3; a++)
            begin
                pn_reg[a] <= pn_next[a];
                pf_reg[a] <= pf_next[a];
            end
        end
    end

    assign ofs_term  = DW'(ofs) <<< aafc_pkg::NORMAL_FRAC_BITS;
    assign dist_near = DW'(pn_reg[0]) + DW'(pn_reg[1]) + DW'(pn_reg[2]) + ofs_term;
    assign dist_far  = DW'(pf_reg[0]) + DW'(pf_reg[1]) + DW'(pf_reg[2]) + ofs_term;

    always_comb
    begin
        s2_item_next = s1_item_reg;
        // outside: nearest corner strictly in front of the plane
        if (!dist_near[DW-1] && (dist_near != '0))
        begin
            s2_item_next.verdict.outside = 1'b1;
        end
        if (!dist_far[DW-1])
        begin
            s2_item_next.verdict.partial = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg && adv2)
        begin
            s2_item_reg <= s2_item_next;
        end
    end

    assign dn_valid = v2_reg;
    assign dn_item  = s2_item_reg;

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !up_ready |-> (v1_reg && v2_reg && !dn_ready))
        else $error("cell stalls with room in its stages");

    a_outside_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && adv2 && s1_item_reg.verdict.outside) |=>
            (v2_reg && s2_item_reg.verdict.outside))
        else $error("outside verdict lost in cell");

    a_partial_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && adv2 && s1_item_reg.verdict.partial) |=>
            (v2_reg && s2_item_reg.verdict.partial))
        else $error("partial verdict lost in cell");
`endif

endmodule

@@ design/aabb_frustum_classify.sv @@
// Top level of the box/frustum classifier: a chain of six plane cells.
// Depends on aafc_pkg and aafc_cell.

// Classifies one axis-aligned box per cycle against six outward-facing
// planes (left, right, top, bottom, near, far at register indexes 0 to 5;
// writes to other indexes are dropped). Each plane is one cell of two
// stages; the chain takes a new box every cycle as long as the output
// side keeps taking results, and a stall backs up only as far as the
// stages are full. Planes reset to zero, which reports every box as
// partially inside. Load planes only while no box is in flight.
module aabb_frustum_classify (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_write,
    input  logic [aafc_pkg::CFG_INDEX_W-1:0]            cfg_index,
    input  logic [aafc_pkg::PLANE_W-1:0]                cfg_data,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic signed [aafc_pkg::COORD_WIDTH-1:0]     min_x,
    input  logic signed [aafc_pkg::COORD_WIDTH-1:0]     min_y,
    input  logic signed [aafc_pkg::COORD_WIDTH-1:0]     min_z,
    input  logic signed [aafc_pkg::COORD_WIDTH-1:0]     max_x,
    input  logic signed [aafc_pkg::COORD_WIDTH-1:0]     max_y,
    input  logic signed [aafc_pkg::COORD_WIDTH-1:0]     max_z,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [1:0]                                  visibility
);

    localparam int N = aafc_pkg::PLANE_COUNT;

    aafc_pkg::item_t link_item  [N+1];
    logic            link_valid [N+1];
    logic            link_ready [N+1];
    aafc_pkg::vis_t  vis;

    always_comb
    begin
        link_item[0].box.min_x = min_x;
        link_item[0].box.min_y = min_y;
        link_item[0].box.min_z = min_z;
        link_item[0].box.max_x = max_x;
        link_item[0].box.max_y = max_y;
        link_item[0].box.max_z = max_z;
        link_item[0].verdict   = '0;
    end

    assign link_valid[0] = in_valid;
    assign in_ready      = link_ready[0];

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        aafc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .plane_write (cfg_write && (cfg_index == aafc_pkg::CFG_INDEX_W'(i))),
            .plane_data  (cfg_data),
            .up_valid    (link_valid[i]),
            .up_ready    (link_ready[i]),
            .up_item     (link_item[i]),
            .dn_valid    (link_valid[i+1]),
            .dn_ready    (link_ready[i+1]),
            .dn_item     (link_item[i+1])
        );
    end

    assign link_ready[N] = out_ready;
    assign out_valid     = link_valid[N];

    always_comb
    begin
        if (link_item[N].verdict.outside)
        begin
            vis = aafc_pkg::VIS_OUTSIDE;
        end
        else if (link_item[N].verdict.partial)
        begin
            vis = aafc_pkg::VIS_PARTIAL;
        end
        else
        begin
            vis = aafc_pkg::VIS_INSIDE;
        end
    end

    assign visibility = vis;

`ifndef SYNTH
    a_code_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (visibility != 2'd3))
        else $error("visibility code out of range");

    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled while output is free");

    a_outside_wins: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && link_item[N].verdict.outside) |->
            (visibility == aafc_pkg::VIS_OUTSIDE))
        else $error("outside box not reported outside");
`endif

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for aabb_frustum_classify: boxes are classified against
// six loaded planes by an in-bench predictor and compared on every result.
// Depends on aafc_pkg and the classifier RTL.
module tb_top;

    localparam logic [aafc_pkg::CFG_INDEX_W-1:0] REG_LEFT   = 3'd0;
    localparam logic [aafc_pkg::CFG_INDEX_W-1:0] REG_RIGHT  = 3'd1;
    localparam logic [aafc_pkg::CFG_INDEX_W-1:0] REG_TOP    = 3'd2;
    localparam logic [aafc_pkg::CFG_INDEX_W-1:0] REG_BOTTOM = 3'd3;
    localparam logic [aafc_pkg::CFG_INDEX_W-1:0] REG_NEAR   = 3'd4;
    localparam logic [aafc_pkg::CFG_INDEX_W-1:0] REG_FAR    = 3'd5;
    localparam logic [aafc_pkg::CFG_INDEX_W-1:0] REG_VOID_A = 3'd6;
    localparam logic [aafc_pkg::CFG_INDEX_W-1:0] REG_VOID_B = 3'd7;

    localparam int UNIT      = 1 << aafc_pkg::NORMAL_FRAC_BITS;
    localparam int DIAG      = 11585;
    localparam int DRAIN_GAP = 16;

    typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_HOLD} rx_mode_t;

    logic                                    clk       = 1'b0;
    logic                                    rst_n     = 1'b0;
    logic                                    cfg_write = 1'b0;
    logic [aafc_pkg::CFG_INDEX_W-1:0]        cfg_index = '0;
    logic [aafc_pkg::PLANE_W-1:0]            cfg_data  = '0;
    logic                                    in_valid  = 1'b0;
    logic                                    in_ready;
    logic signed [aafc_pkg::COORD_WIDTH-1:0] min_x     = '0;
    logic signed [aafc_pkg::COORD_WIDTH-1:0] min_y     = '0;
    logic signed [aafc_pkg::COORD_WIDTH-1:0] min_z     = '0;
    logic signed [aafc_pkg::COORD_WIDTH-1:0] max_x     = '0;
    logic signed [aafc_pkg::COORD_WIDTH-1:0] max_y     = '0;
    logic signed [aafc_pkg::COORD_WIDTH-1:0] max_z     = '0;
    logic                                    out_valid;
    logic                                    out_ready = 1'b0;
    logic [1:0]                              visibility;

    logic [aafc_pkg::PLANE_W-1:0] plane_regs [aafc_pkg::PLANE_COUNT];
    aafc_pkg::box_t               box_queue [$];
    aafc_pkg::vis_t               expected_vis [$];
    aafc_pkg::box_t               cur_box;
    aafc_pkg::vis_t               want;
    int                           boxes_queued = 0;
    int                           boxes_sent   = 0;
    int                           mismatches   = 0;
    int                           gap_max      = 0;
    int                           burst_left   = 0;
    int                           gap_left     = 0;
    int                           rx_cycle     = 0;
    rx_mode_t                     rx_mode      = RX_STEADY;

    aabb_frustum_classify uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .min_x      (min_x),
        .min_y      (min_y),
        .min_z      (min_z),
        .max_x      (max_x),
        .max_y      (max_y),
        .max_z      (max_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .visibility (visibility)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Nearest and farthest corners per plane follow the signs of the normal;
    // a zero component counts as positive.
    function automatic aafc_pkg::vis_t classify_box(input aafc_pkg::box_t b);
        longint lo [3];
        longint hi [3];
        longint nrm;
        longint d_near;
        longint d_far;
        logic   partial;
        int     p;
        int     a;
        lo[0] = b.min_x;
        lo[1] = b.min_y;
        lo[2] = b.min_z;
        hi[0] = b.max_x;
        hi[1] = b.max_y;
        hi[2] = b.max_z;
        partial = 1'b0;
        for (p = 0; p < aafc_pkg::PLANE_COUNT; p++)
        begin
            d_near = longint'($signed(plane_regs[p][63:48])) <<< aafc_pkg::NORMAL_FRAC_BITS;
            d_far  = d_near;
            for (a = 0; a < 3; a++)
            begin
                nrm = longint'($signed(plane_regs[p][16*a +: 16]));
                if (nrm >= 0)
                begin
                    d_near += nrm * lo[a];
                    d_far  += nrm * hi[a];
                end
                else
                begin
                    d_near += nrm * hi[a];
                    d_far  += nrm * lo[a];
                end
            end
            if (d_near > 0)
                return aafc_pkg::VIS_OUTSIDE;
            if (d_far >= 0)
                partial = 1'b1;
        end
        return partial ? aafc_pkg::VIS_PARTIAL : aafc_pkg::VIS_INSIDE;
    endfunction

    function automatic logic [aafc_pkg::PLANE_W-1:0] pack_plane(input int nx, input int ny,
                                                                input int nz, input int ofs);
        return {ofs[15:0], nz[15:0], ny[15:0], nx[15:0]};
    endfunction

    function automatic aafc_pkg::box_t mk_box(input int ax, input int ay, input int az,
                                              input int bx, input int by, input int bz);
        aafc_pkg::box_t b;
        b.min_x = ax[15:0];
        b.min_y = ay[15:0];
        b.min_z = az[15:0];
        b.max_x = bx[15:0];
        b.max_y = by[15:0];
        b.max_z = bz[15:0];
        return b;
    endfunction

    function automatic int clamp16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 6))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            5:       return -UNIT;
            default: return UNIT;
        endcase
    endfunction

    task automatic queue_box(input aafc_pkg::box_t b);
        box_queue.push_back(b);
        boxes_queued++;
    endtask

    // Centred box with random extents; now and then flip an axis or take
    // raw bits so that every input bit toggles.
    task automatic queue_rand_box(input int span, input int ext_max);
        int             lo [3];
        int             hi [3];
        int             c;
        int             e;
        int             t;
        int             a;
        aafc_pkg::box_t b;
        for (a = 0; a < 3; a++)
        begin
            c = int'($urandom_range(0, 2 * span)) - span;
            e = $urandom_range(0, ext_max);
            lo[a] = clamp16(c - e);
            hi[a] = clamp16(c + e);
            if ($urandom_range(0, 15) == 0)
            begin
                t     = lo[a];
                lo[a] = hi[a];
                hi[a] = t;
            end
        end
        b = mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
        if ($urandom_range(0, 15) == 0)
            b = {$urandom, $urandom, $urandom};
        queue_box(b);
    endtask

    task automatic write_plane(input logic [aafc_pkg::CFG_INDEX_W-1:0] idx,
                               input logic [aafc_pkg::PLANE_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx < aafc_pkg::PLANE_COUNT)
            plane_regs[idx] = data;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic load_planes(input logic [aafc_pkg::PLANE_W-1:0] l,
                               input logic [aafc_pkg::PLANE_W-1:0] r,
                               input logic [aafc_pkg::PLANE_W-1:0] t,
                               input logic [aafc_pkg::PLANE_W-1:0] b,
                               input logic [aafc_pkg::PLANE_W-1:0] n,
                               input logic [aafc_pkg::PLANE_W-1:0] f);
        write_plane(REG_LEFT, l);
        write_plane(REG_RIGHT, r);
        write_plane(REG_TOP, t);
        write_plane(REG_BOTTOM, b);
        write_plane(REG_NEAR, n);
        write_plane(REG_FAR, f);
    endtask

    task automatic load_cube(input int w);
        load_planes(pack_plane(-UNIT, 0, 0, -w), pack_plane(UNIT, 0, 0, -w),
                    pack_plane(0, UNIT, 0, -w), pack_plane(0, -UNIT, 0, -w),
                    pack_plane(0, 0, -UNIT, -w), pack_plane(0, 0, UNIT, -w));
    endtask

    // Hold until every box is through and checked, then let the chain empty.
    task automatic settle();
        while (boxes_sent != boxes_queued || expected_vis.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    // Sender: bursts of transfers separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_vis.push_back(classify_box(cur_box));
                boxes_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (box_queue.size() != 0)
                begin
                    cur_box = box_queue.pop_front();
                    in_valid <= 1'b1;
                    min_x    <= cur_box.min_x;
                    min_y    <= cur_box.min_y;
                    min_z    <= cur_box.min_z;
                    max_x    <= cur_box.max_x;
                    max_y    <= cur_box.max_y;
                    max_z    <= cur_box.max_z;
                    if (burst_left > 0)
                        burst_left--;
                    else if (gap_max > 0)
                    begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = $urandom_range(1, gap_max);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern chosen per phase; the hold pattern backs the
    // chain up by holding out_ready low at the start of each period.
    always @(posedge clk)
    begin
        rx_cycle++;
        case (rx_mode)
            RX_STEADY:   out_ready <= 1'b1;
            RX_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: out_ready <= (rx_cycle % 7 != 0) && (rx_cycle % 7 != 3);
            RX_HOLD:     out_ready <= (rx_cycle % 400 >= 150);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_vis.size() == 0)
            begin
                $display("%0t: result with none pending: expected none, actual %0d",
                         $time, visibility);
                mismatches++;
            end
            else
            begin
                want = expected_vis.pop_front();
                if (visibility !== want)
                begin
                    $display("%0t: visibility mismatch: expected %0d, actual %0d",
                             $time, want, visibility);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int i;
        int w;
        int far_z;
        for (i = 0; i < aafc_pkg::PLANE_COUNT; i++)
            plane_regs[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zeroed planes: every box, however odd, is partial
        queue_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        queue_box(mk_box(0, 0, 0, 0, 0, 0));
        queue_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
        queue_box(mk_box(-1, -1, -1, -1, -1, -1));
        settle();

        // Axis-aligned cube frustum: touching faces, one unit either side, swapped corners
        w = 1000;
        load_cube(w);
        queue_box(mk_box(-10, -10, -10, 10, 10, 10));
        queue_box(mk_box(-10, -10, -10, w, 10, 10));
        queue_box(mk_box(-10, -10, -10, w - 1, 10, 10));
        queue_box(mk_box(w, -10, -10, w + 200, 10, 10));
        queue_box(mk_box(w + 1, -10, -10, w + 200, 10, 10));
        queue_box(mk_box(-w, -10, -10, 10, 10, 10));
        queue_box(mk_box(-10, -10, -10, 10, 10, w));
        queue_box(mk_box(-10, -10, w + 1, 10, 10, 2 * w));
        queue_box(mk_box(10, 10, 10, -10, -10, -10));
        queue_box(mk_box(2 * w, 0, 0, -2 * w, 0, 0));
        queue_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        queue_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        queue_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        gap_max = 4;
        rx_mode = RX_RANDOM;
        for (i = 0; i < 300; i++)
            queue_rand_box(2 * w, w / 2);
        settle();

        // Perspective frustum looking down +z
        far_z = $urandom_range(2000, 20000);
        load_planes(pack_plane(-DIAG, 0, -DIAG, 0), pack_plane(DIAG, 0, -DIAG, 0),
                    pack_plane(0, DIAG, -DIAG, 0), pack_plane(0, -DIAG, -DIAG, 0),
                    pack_plane(0, 0, -UNIT, 16), pack_plane(0, 0, UNIT, -far_z));
        gap_max = 8;
        rx_mode = RX_PERIODIC;
        for (i = 0; i < 400; i++)
            queue_rand_box(far_z, far_z / 8);
        settle();

        // Back-pressure: sender never idles while the receiver holds off
        w = $urandom_range(200, 8000);
        load_cube(w);
        gap_max = 0;
        rx_mode = RX_HOLD;
        for (i = 0; i < 300; i++)
            queue_rand_box(2 * w, w / 2);
        settle();

        // Extreme plane fields; writes beyond the last plane must be dropped
        load_planes(64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF,
                    64'h8000_8000_8000_8000,
                    pack_plane(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()),
                    pack_plane(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()),
                    pack_plane(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()));
        write_plane(REG_VOID_A, {$urandom, $urandom});
        write_plane(REG_VOID_B, 64'hFFFF_FFFF_FFFF_FFFF);
        gap_max = 3;
        rx_mode = RX_RANDOM;
        for (i = 0; i < 150; i++)
            queue_rand_box(32767, 2000);
        settle();

        load_planes({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        gap_max = 5;
        rx_mode = RX_PERIODIC;
        for (i = 0; i < 150; i++)
            queue_rand_box(32767, 8000);
        settle();

        // Wide cube near the coordinate limits, no idling on either side
        load_cube(30000);
        gap_max = 0;
        rx_mode = RX_STEADY;
        for (i = 0; i < 200; i++)
            queue_rand_box(32767, 4000);
        settle();

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
